### hw/rtl/pva_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pva_pkg
// Shared types and constants of the polyphonic voice allocator.
// ----------------------------------------------------------------------------
package pva_pkg;

   localparam int PITCH_W    = 32;
   localparam int VEL_W      = 32;
   localparam int AGE_W      = 64;
   localparam int VOICE_W    = 8;
   // Widest voice address the table can need (128 voices).
   localparam int ADDR_MAX_W = 7;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_VOICE_LIMIT  = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STEAL_ENABLE = 8'd1;

   localparam logic [VOICE_W-1:0] VOICE_LIMIT_RESET  = 8'd16;
   localparam logic               STEAL_ENABLE_RESET = 1'b0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FREE,
      ST_SCAN,
      ST_EMIT,
      ST_STOP
   } pva_state_type;

   typedef enum logic [1:0] {
      ACT_TAKE,
      ACT_OVF,
      ACT_OFF,
      ACT_STEAL
   } pva_act_type;

   typedef struct packed {
      logic                      rd_en;
      logic                      take_en;
      logic                      rel_en;
      logic [ADDR_MAX_W-1:0]     addr;
      logic signed [PITCH_W-1:0] take_pitch;
   } pva_store_cmd_type;

endpackage
`default_nettype wire

### hw/rtl/poly_voice_allocator_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// poly_voice_allocator_core
// Polyphonic voice allocator with oldest-voice stealing.
// ----------------------------------------------------------------------------
// A note beat on the req_ channel carries a type, a pitch and a velocity. Each
// request produces zero or more result beats on the rsp_ channel; rsp_last marks
// the final one. The csr_ port writes the voice limit and the steal enable and
// is always ready; the user must write it only while the block is idle; the
// block does not enforce it. One request is handled at a time; req_stall is
// high while one is in progress. The voice memory has one port, so the table
// is visited one entry at a time:
//   note-on        : free search of the first L entries (L = limit); with
//                    stealing and no free entry, an oldest search of them
//   note-off       : whole-table search for the oldest voice of that pitch
//   stop           : walk up to the highest active voice, releasing each one
// Results leave through an output register; while the receiver holds rsp_stall
// the sequencer waits with the next result and the beat on the port holds.
// Reset clears all active bits, the count, the age counter and the control
// registers at once; no clearing pass of the memory is needed.
// ----------------------------------------------------------------------------
module poly_voice_allocator_core #(
   parameter int TABLE_VOICES = 64
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic                                req_type,
   input  wire logic signed [pva_pkg::PITCH_W-1:0]  req_pitch,
   input  wire logic signed [pva_pkg::VEL_W-1:0]    req_velocity,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic                                     rsp_event_kind,
   output logic [pva_pkg::VOICE_W-1:0]              rsp_voice_number,
   output logic signed [pva_pkg::PITCH_W-1:0]       rsp_note_pitch,
   output logic signed [pva_pkg::VEL_W-1:0]         rsp_note_velocity,
   output logic                                     rsp_last,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [pva_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [pva_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import pva_pkg::*;

   localparam int AW = (TABLE_VOICES > 1) ? $clog2(TABLE_VOICES) : 1;
   localparam int CW = $clog2(TABLE_VOICES+1);
   localparam logic [VOICE_W-1:0] TABLE_VOICES_V = VOICE_W'(TABLE_VOICES);

   pva_state_type             state_ff, state_in;
   pva_act_type               act_ff, act_in;
   logic [CW-1:0]             idx_ff, idx_in;
   logic [AW-1:0]             act_idx_ff, act_idx_in;
   logic                      pipe_vld_ff, pipe_vld_in;
   logic [AW-1:0]             pipe_idx_ff, pipe_idx_in;
   logic                      found_ff, found_in;
   logic [AGE_W-1:0]          best_age_ff, best_age_in;
   logic [AW-1:0]             best_idx_ff, best_idx_in;
   logic signed [PITCH_W-1:0] best_pitch_ff, best_pitch_in;
   logic signed [PITCH_W-1:0] item_pitch_ff, item_pitch_in;
   logic signed [VEL_W-1:0]   item_vel_ff, item_vel_in;
   logic                      item_off_ff, item_off_in;
   logic                      stop_wait_ff, stop_wait_in;
   logic [VOICE_W-1:0]        voice_limit_ff;
   logic                      steal_enable_ff;

   logic                      rsp_valid_ff;
   logic                      rsp_kind_ff;
   logic [VOICE_W-1:0]        rsp_voice_ff;
   logic signed [PITCH_W-1:0] rsp_pitch_ff;
   logic signed [VEL_W-1:0]   rsp_vel_ff;
   logic                      rsp_last_ff;

   logic                      load;
   logic                      ld_kind;
   logic [VOICE_W-1:0]        ld_voice;
   logic signed [PITCH_W-1:0] ld_pitch;
   logic signed [VEL_W-1:0]   ld_vel;
   logic                      ld_last;

   pva_store_cmd_type         cmd;
   logic [TABLE_VOICES-1:0]   active_vec;
   logic [CW-1:0]             active_count;
   logic signed [PITCH_W-1:0] rd_pitch;
   logic [AGE_W-1:0]          rd_age;

   logic                      req_fire;
   logic                      slot_free;
   logic [VOICE_W-1:0]        eff_limit;
   logic [VOICE_W-1:0]        idx8;
   logic [VOICE_W-1:0]        scan_end;
   logic [AW-1:0]             idx_a;
   logic                      free_end;
   logic                      free_hit;
   logic                      scan_issue;
   logic                      scan_done;
   logic                      scan_hit;

   pva_voice_store #(
      .TABLE_VOICES (TABLE_VOICES)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .active_out (active_vec),
      .count_out  (active_count),
      .rd_pitch   (rd_pitch),
      .rd_age     (rd_age)
   );

   // A limit of zero behaves as one voice; anything above the table as the table.
   assign eff_limit = (voice_limit_ff == '0) ? VOICE_W'(1) :
                      ((voice_limit_ff > TABLE_VOICES_V) ? TABLE_VOICES_V : voice_limit_ff);

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_fire   = req_valid && !req_stall;
   assign slot_free  = !rsp_valid_ff || !rsp_stall;
   assign idx8       = VOICE_W'(idx_ff);
   assign idx_a      = idx_ff[AW-1:0];
   assign scan_end   = item_off_ff ? TABLE_VOICES_V : eff_limit;
   assign free_end   = (idx8 == eff_limit);
   assign free_hit   = !active_vec[idx_a];
   assign scan_issue = (idx8 != scan_end);
   assign scan_done  = !scan_issue && !pipe_vld_ff;
   // Compare stage of the scan: the read data belongs to pipe_idx_ff.
   assign scan_hit   = pipe_vld_ff && active_vec[pipe_idx_ff] &&
                       (!item_off_ff || (rd_pitch == item_pitch_ff)) &&
                       (!found_ff || (rd_age < best_age_ff));

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_type) begin
                  state_in = ST_STOP;
               end else if (req_velocity == '0) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_FREE;
               end
            end
         end
         ST_FREE: begin
            if (free_end) begin
               state_in = steal_enable_ff ? ST_SCAN : ST_EMIT;
            end else if (free_hit) begin
               state_in = ST_EMIT;
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (slot_free && (act_ff != ACT_STEAL)) begin
               state_in = ST_IDLE;
            end
         end
         ST_STOP: begin
            if (!stop_wait_ff && (active_count == '0)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer datapath, memory commands and result loading.
   always_comb begin
      act_in        = act_ff;
      act_idx_in    = act_idx_ff;
      idx_in        = idx_ff;
      pipe_vld_in   = 1'b0;
      pipe_idx_in   = pipe_idx_ff;
      found_in      = found_ff;
      best_age_in   = best_age_ff;
      best_idx_in   = best_idx_ff;
      best_pitch_in = best_pitch_ff;
      item_pitch_in = item_pitch_ff;
      item_vel_in   = item_vel_ff;
      item_off_in   = item_off_ff;
      stop_wait_in  = stop_wait_ff;
      load          = 1'b0;
      ld_kind       = 1'b0;
      ld_voice      = '0;
      ld_pitch      = item_pitch_ff;
      ld_vel        = item_vel_ff;
      ld_last       = 1'b1;
      cmd           = '0;
      cmd.take_pitch = item_pitch_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               item_pitch_in = req_pitch;
               item_vel_in   = req_velocity;
               item_off_in   = (req_velocity == '0);
               idx_in        = '0;
               found_in      = 1'b0;
               stop_wait_in  = 1'b0;
            end
         end
         ST_FREE: begin
            if (free_end) begin
               act_in   = ACT_OVF;
               idx_in   = '0;
               found_in = 1'b0;
            end else if (free_hit) begin
               act_in     = ACT_TAKE;
               act_idx_in = idx_a;
            end else begin
               idx_in = idx_ff + CW'(1);
            end
         end
         ST_SCAN: begin
            if (scan_issue) begin
               cmd.rd_en   = 1'b1;
               cmd.addr    = ADDR_MAX_W'(idx_a);
               idx_in      = idx_ff + CW'(1);
               pipe_vld_in = 1'b1;
               pipe_idx_in = idx_a;
            end
            if (scan_hit) begin
               found_in      = 1'b1;
               best_age_in   = rd_age;
               best_idx_in   = pipe_idx_ff;
               best_pitch_in = rd_pitch;
            end
            if (scan_done) begin
               act_idx_in = best_idx_ff;
               if (!found_ff) begin
                  act_in = ACT_OVF;
               end else if (item_off_ff) begin
                  act_in = ACT_OFF;
               end else begin
                  act_in = ACT_STEAL;
               end
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               load     = 1'b1;
               cmd.addr = ADDR_MAX_W'(act_idx_ff);
               ld_voice = VOICE_W'(act_idx_ff) + VOICE_W'(1);
               case (act_ff)
                  ACT_TAKE: begin
                     cmd.take_en = 1'b1;
                  end
                  ACT_OVF: begin
                     ld_kind  = 1'b1;
                     ld_voice = '0;
                  end
                  ACT_OFF: begin
                     cmd.rel_en = 1'b1;
                     ld_vel     = '0;
                  end
                  ACT_STEAL: begin
                     // Release beat of the victim; the new note follows on it.
                     cmd.rel_en = 1'b1;
                     ld_pitch   = best_pitch_ff;
                     ld_vel     = '0;
                     ld_last    = 1'b0;
                     act_in     = ACT_TAKE;
                  end
                  default: begin
                     ld_kind  = 1'b1;
                     ld_voice = '0;
                  end
               endcase
            end
         end
         ST_STOP: begin
            if (!stop_wait_ff) begin
               if (active_count != '0) begin
                  if (active_vec[idx_a]) begin
                     cmd.rd_en    = 1'b1;
                     cmd.addr     = ADDR_MAX_W'(idx_a);
                     stop_wait_in = 1'b1;
                  end else begin
                     idx_in = idx_ff + CW'(1);
                  end
               end
            end else if (slot_free) begin
               // The read data register holds the pitch until the beat is taken.
               load         = 1'b1;
               cmd.rel_en   = 1'b1;
               cmd.addr     = ADDR_MAX_W'(idx_a);
               ld_voice     = idx8 + VOICE_W'(1);
               ld_pitch     = rd_pitch;
               ld_vel       = '0;
               ld_last      = (active_count == CW'(1));
               idx_in       = idx_ff + CW'(1);
               stop_wait_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         pipe_vld_ff     <= 1'b0;
         stop_wait_ff    <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         voice_limit_ff  <= VOICE_LIMIT_RESET;
         steal_enable_ff <= STEAL_ENABLE_RESET;
      end else begin
         state_ff     <= state_in;
         pipe_vld_ff  <= pipe_vld_in;
         stop_wait_ff <= stop_wait_in;
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_VOICE_LIMIT:  voice_limit_ff  <= csr_wdata;
               CSR_STEAL_ENABLE: steal_enable_ff <= csr_wdata[0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      act_idx_ff    <= act_idx_in;
      idx_ff        <= idx_in;
      pipe_idx_ff   <= pipe_idx_in;
      found_ff      <= found_in;
      best_age_ff   <= best_age_in;
      best_idx_ff   <= best_idx_in;
      best_pitch_ff <= best_pitch_in;
      item_pitch_ff <= item_pitch_in;
      item_vel_ff   <= item_vel_in;
      item_off_ff   <= item_off_in;
      if (load) begin
         rsp_kind_ff  <= ld_kind;
         rsp_voice_ff <= ld_voice;
         rsp_pitch_ff <= ld_pitch;
         rsp_vel_ff   <= ld_vel;
         rsp_last_ff  <= ld_last;
      end
   end

   assign csr_ready         = 1'b1;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_event_kind    = rsp_kind_ff;
   assign rsp_voice_number  = rsp_voice_ff;
   assign rsp_note_pitch    = rsp_pitch_ff;
   assign rsp_note_velocity = rsp_vel_ff;
   assign rsp_last          = rsp_last_ff;

   a_read_only_scanning : assert property (@(posedge clock) disable iff (reset)
      cmd.rd_en |-> ((state_ff == ST_SCAN) || (state_ff == ST_STOP)))
      else $error("voice memory read outside a scan");

   a_steal_then_take : assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_EMIT) && (act_ff == ACT_STEAL) && slot_free)
      |=> ((state_ff == ST_EMIT) && (act_ff == ACT_TAKE)))
      else $error("stolen voice not retaken by the new note");

   a_overflow_is_last : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff) |-> (rsp_last_ff && (rsp_voice_ff == '0)))
      else $error("overflow beat not marked last");

endmodule
`default_nettype wire

### hw/rtl/pva_voice_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pva_voice_store
// Voice table: pitch and age memory with a registered read port, active bits,
// active count and the age counter.
// ----------------------------------------------------------------------------
module pva_voice_store #(
   parameter int TABLE_VOICES = 64
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire pva_pkg::pva_store_cmd_type         cmd,
   output logic [TABLE_VOICES-1:0]                 active_out,
   output logic [$clog2(TABLE_VOICES+1)-1:0]       count_out,
   output logic signed [pva_pkg::PITCH_W-1:0]      rd_pitch,
   output logic [pva_pkg::AGE_W-1:0]               rd_age
);
   import pva_pkg::*;

   localparam int AW = (TABLE_VOICES > 1) ? $clog2(TABLE_VOICES) : 1;
   localparam int CW = $clog2(TABLE_VOICES+1);

   logic [PITCH_W+AGE_W-1:0] voice_mem [TABLE_VOICES];
   logic [PITCH_W+AGE_W-1:0] rd_data_ff;
   logic [TABLE_VOICES-1:0]  voice_active_ff, voice_active_in;
   logic [CW-1:0]            count_ff, count_in;
   logic [AGE_W-1:0]         age_counter_ff, age_counter_in;
   logic [AW-1:0]            addr_a;

   assign addr_a = cmd.addr[AW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.take_en) begin
         voice_mem[addr_a] <= {cmd.take_pitch, age_counter_ff};
      end
      if (cmd.rd_en) begin
         rd_data_ff <= voice_mem[addr_a];
      end
   end

   always_comb begin
      voice_active_in = voice_active_ff;
      count_in        = count_ff;
      age_counter_in  = age_counter_ff;
      if (cmd.take_en) begin
         voice_active_in[addr_a] = 1'b1;
         count_in                = count_ff + CW'(1);
         age_counter_in          = age_counter_ff + AGE_W'(1);
      end
      if (cmd.rel_en) begin
         voice_active_in[addr_a] = 1'b0;
         count_in                = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         voice_active_ff <= '0;
         count_ff        <= '0;
         age_counter_ff  <= '0;
      end else begin
         voice_active_ff <= voice_active_in;
         count_ff        <= count_in;
         age_counter_ff  <= age_counter_in;
      end
   end

   assign active_out = voice_active_ff;
   assign count_out  = count_ff;
   assign rd_pitch   = rd_data_ff[PITCH_W+AGE_W-1:AGE_W];
   assign rd_age     = rd_data_ff[AGE_W-1:0];

   a_count_matches : assert property (@(posedge clock) disable iff (reset)
      $countones(voice_active_ff) == int'(count_ff))
      else $error("active count out of step with active bits");

   a_take_free : assert property (@(posedge clock) disable iff (reset)
      cmd.take_en |-> !voice_active_ff[addr_a] && !cmd.rel_en)
      else $error("voice taken while still active");

   a_release_active : assert property (@(posedge clock) disable iff (reset)
      cmd.rel_en |-> voice_active_ff[addr_a])
      else $error("release of an inactive voice");

endmodule
`default_nettype wire
